// ===== rtl/prf_pkg.sv =====
`timescale 1ns / 1ps

package prf_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
        logic [31:0] data;
        logic [7:0]  service;
        logic [1:0]  mode;
        logic [31:0] path_first;
    } t_rec;

    typedef struct packed {
        logic [31:0] second;
        logic [31:0] third;
    } t_path23;

endpackage

// ===== rtl/packet_record_fifo_top.sv =====
`timescale 1ns / 1ps

// Circular queue of packet-control records that keeps one slot empty, so it holds at most
// QUEUE_SLOTS - 1 records. Every item, push or pop, produces exactly one result item in
// order. One item can be accepted in every clock cycle while results are taken as they come.
// The record memory is read and the first stage register loads at the edge that accepts an
// item. The output register loads from the first stage register when it is empty or its
// result is taken; it holds the result until taken. While a result is held back,
// one further item is accepted and then the input stalls. A push to a full queue returns
// status full and stores nothing; a pop on an empty queue returns status empty. Record
// fields are zero in any result that is not a successful pop. The path service code
// register must only be written while the queue has no item in flight.
module packet_record_fifo_top #(
    parameter int QUEUE_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [15:0] i_src_addr,
    input  logic [15:0] i_dst_addr,
    input  logic [31:0] i_data_word,
    input  logic [7:0]  i_service_code,
    input  logic [1:0]  i_mode_bits,
    input  logic [31:0] i_path_in_first,
    input  logic [31:0] i_path_in_second,
    input  logic [31:0] i_path_in_third,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_head_src,
    output logic [15:0] o_head_dst,
    output logic [31:0] o_head_data,
    output logic [7:0]  o_head_service,
    output logic [1:0]  o_head_mode,
    output logic [31:0] o_head_path_first,
    output logic [31:0] o_head_path_second,
    output logic [31:0] o_head_path_third
);

    localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] n_tail;
    logic [7:0]       r_path_code;

    logic             r_s1_valid;
    logic [1:0]       r_s1_status;
    logic             r_s1_rec;

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    prf_pkg::t_rec    r_out_rec;
    prf_pkg::t_path23 r_out_p23;

    logic             in_acc;
    logic             is_push;
    logic             full;
    logic             empty;
    logic             push_ok;
    logic             pop_ok;
    logic             s1_move;
    logic [1:0]       acc_status;
    prf_pkg::t_rec    wr_rec;
    prf_pkg::t_path23 wr_p23;
    prf_pkg::t_rec    rd_rec;
    prf_pkg::t_path23 rd_p23;

    assign n_head  = (r_head == LAST_SLOT) ? '0 : r_head + PTR_W'(1);
    assign n_tail  = (r_tail == LAST_SLOT) ? '0 : r_tail + PTR_W'(1);
    assign full    = (n_tail == r_head);
    assign empty   = (r_head == r_tail);
    assign is_push = (i_operation == prf_pkg::OP_PUSH);

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;
    assign push_ok    = in_acc && is_push && !full;
    assign pop_ok     = in_acc && !is_push && !empty;

    always_comb begin
        if (is_push) begin
            acc_status = full ? prf_pkg::ST_FULL : prf_pkg::ST_DONE;
        end else begin
            acc_status = empty ? prf_pkg::ST_EMPTY : prf_pkg::ST_DONE;
        end
    end

    assign wr_rec.src        = i_src_addr;
    assign wr_rec.dst        = i_dst_addr;
    assign wr_rec.data       = i_data_word;
    assign wr_rec.service    = i_service_code;
    assign wr_rec.mode       = i_mode_bits;
    assign wr_rec.path_first = i_path_in_first;
    assign wr_p23.second     = i_path_in_second;
    assign wr_p23.third      = i_path_in_third;

    prf_rec_mem #(
        .SLOTS (QUEUE_SLOTS),
        .PTR_W (PTR_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (push_ok),
        .i_wr_p23_en (i_service_code == r_path_code),
        .i_wr_addr   (r_tail),
        .i_wr_rec    (wr_rec),
        .i_wr_p23    (wr_p23),
        .i_rd_en     (pop_ok),
        .i_rd_addr   (r_head),
        .o_rd_rec    (rd_rec),
        .o_rd_p23    (rd_p23)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_path_code <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_path_code <= i_cfg_data;
            end
            if (push_ok) begin
                r_tail <= n_tail;
            end
            if (pop_ok) begin
                r_head <= n_head;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= acc_status;
            r_s1_rec    <= pop_ok;
        end
        if (s1_move) begin
            r_out_status <= r_s1_status;
            r_out_rec    <= r_s1_rec ? rd_rec : '0;
            r_out_p23    <= r_s1_rec ? rd_p23 : '0;
        end
    end

    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_head_src         = r_out_rec.src;
    assign o_head_dst         = r_out_rec.dst;
    assign o_head_data        = r_out_rec.data;
    assign o_head_service     = r_out_rec.service;
    assign o_head_mode        = r_out_rec.mode;
    assign o_head_path_first  = r_out_rec.path_first;
    assign o_head_path_second = r_out_p23.second;
    assign o_head_path_third  = r_out_p23.third;

endmodule

// ===== rtl/prf_rec_mem.sv =====
`timescale 1ns / 1ps

module prf_rec_mem #(
    parameter int SLOTS = 8,
    parameter int PTR_W = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic                 i_wr_p23_en,
    input  logic [PTR_W-1:0]     i_wr_addr,
    input  prf_pkg::t_rec        i_wr_rec,
    input  prf_pkg::t_path23     i_wr_p23,
    input  logic                 i_rd_en,
    input  logic [PTR_W-1:0]     i_rd_addr,
    output prf_pkg::t_rec        o_rd_rec,
    output prf_pkg::t_path23     o_rd_p23
);

    prf_pkg::t_rec    r_rec_mem [SLOTS];
    prf_pkg::t_path23 r_p23_mem [SLOTS];
    logic [SLOTS-1:0] r_p23_vld;
    prf_pkg::t_rec    r_rd_rec;
    prf_pkg::t_path23 r_rd_p23;
    logic             r_rd_p23_ok;

    // Path words two and three read zero until written with i_wr_p23_en set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p23_vld <= '0;
        end else if (i_wr_en && i_wr_p23_en) begin
            r_p23_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_rec_mem[i_wr_addr] <= i_wr_rec;
        end
        if (i_wr_en && i_wr_p23_en) begin
            r_p23_mem[i_wr_addr] <= i_wr_p23;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_rec    <= r_rec_mem[i_rd_addr];
            r_rd_p23    <= r_p23_mem[i_rd_addr];
            r_rd_p23_ok <= r_p23_vld[i_rd_addr];
        end
    end

    assign o_rd_rec = r_rd_rec;
    assign o_rd_p23 = r_rd_p23_ok ? r_rd_p23 : '0;

endmodule

// ===== rtl/prf_checker.sv =====
`timescale 1ns / 1ps

module prf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_head_src,
    input logic [31:0] o_head_data,
    input logic [31:0] o_head_path_second
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)))
        else $error("result item dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item shown right after reset");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != prf_pkg::ST_DONE)
            |-> (o_head_src == '0 && o_head_data == '0 && o_head_path_second == '0))
        else $error("refused item carries record fields");

endmodule

bind packet_record_fifo_top prf_checker u_prf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_status           (o_status),
    .o_head_src         (o_head_src),
    .o_head_data        (o_head_data),
    .o_head_path_second (o_head_path_second)
);
